// ===== rtl/mfdi_pkg.sv =====
// Shared types, constants and the logistic table builder for the density iterator.
`timescale 1ns / 1ps
package mfdi_pkg;

   localparam int MAX_DEGREE  = 16;
   localparam int TABLE_BITS  = 10;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int TAB_AW      = TABLE_BITS + 1;
   localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
   localparam int POW_W       = 31;
   localparam int ROW_W       = MAX_DEGREE;
   localparam int SUM_W       = ROW_W + POW_W + DEG_W;
   localparam int DIV_W       = 16 + DEG_W + TABLE_BITS + 1;
   localparam int DCNT_W      = $clog2(DIV_W);
   localparam int QIDX_W      = DIV_W - 16;

   localparam logic [16:0]      ONE_Q16 = 17'h10000;
   localparam logic [POW_W-1:0] ONE_POW = POW_W'(32'h4000_0000);

   // configuration register indexes
   localparam logic [1:0] REG_DEGREE     = 2'd0;
   localparam logic [1:0] REG_LOW_THRESH = 2'd1;
   localparam logic [1:0] REG_NOISE_RATE = 2'd2;
   localparam logic [1:0] REG_ITER_COUNT = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PASCAL, OP_RATE, OP_DIV, OP_RD_A, OP_RD_B,
      OP_INTERP, OP_CP, OP_TW, OP_TT, OP_TACC, OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic band;
      logic div_last;
   } stat_type;

   typedef logic [16:0] lut_type [0:TABLE_SIZE];

   // restoring shift-subtract quotient, used only while building the table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Logistic samples 65536/(1+exp(-x)), x stepping by 16/TABLE_SIZE.
   // exp step is a Taylor series in Q2.62, then repeated products.
   function automatic lut_type build_logistic();
      lut_type     lut;
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] a1;
      logic [63:0] a0;
      logic [63:0] b1;
      logic [63:0] b0;
      logic [63:0] mid;
      int          s;
      s = TABLE_BITS - 4;
      t = 64'h4000_0000_0000_0000;
      r = t;
      e = t;
      for (int m = 1; m < 64; m++) begin
         if (t != 64'd0) begin
            t = udiv64(t >> s, 64'(m));
            if ((m & 1) == 1) r = r - t;
            else r = r + t;
         end
      end
      for (int n = 0; n <= TABLE_SIZE; n++) begin
         den    = 64'h4000_0000 + (e >> 32);
         lut[n] = 17'(udiv64((64'd1 << 46) + (den >> 1), den));
         a1     = e >> 31;
         a0     = e & 64'h7FFF_FFFF;
         b1     = r >> 31;
         b0     = r & 64'h7FFF_FFFF;
         mid    = a1 * b0 + a0 * b1 + ((a0 * b0) >> 31);
         e      = a1 * b1 + (mid >> 31);
      end
      return lut;
   endfunction

endpackage

// ===== rtl/mean_field_density_iterator.sv =====
// Top level of the mean-field density iterator: CSR bank, sequencer and datapath.
// Each item runs a prologue and then N = iteration_count map iterations at degree k;
// the prologue builds the binomial rows, then rates each term, directly outside
// the logistic band or inside it by a restoring divide and two ROM reads.
// Throughput: one item at a time; start is taken only while busy is low.
// Reset is synchronous; the result strobe lasts one cycle, the receiver cannot stall.
`timescale 1ns / 1ps
module mean_field_density_iterator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_coupling,
   input  logic [16:0]        req_start_density,
   output logic               rsp_valid,
   output logic [16:0]        rsp_final_density,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);

   logic [4:0]  degree_ff;
   logic [16:0] low_thresh_ff;
   logic [16:0] noise_rate_ff;
   logic [15:0] iter_count_ff;

   mfdi_pkg::cmd_type  cmd;
   mfdi_pkg::stat_type status;

   assign csr_ready = 1'b1;

   // configuration registers, one transfer per write
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= 5'd4;
         low_thresh_ff <= 17'd0;
         noise_rate_ff <= 17'd0;
         iter_count_ff <= 16'd1000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mfdi_pkg::REG_DEGREE:     degree_ff     <= csr_data[4:0];
            mfdi_pkg::REG_LOW_THRESH: low_thresh_ff <= csr_data;
            mfdi_pkg::REG_NOISE_RATE: noise_rate_ff <= csr_data;
            mfdi_pkg::REG_ITER_COUNT: iter_count_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   mfdi_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .cfg_iteration_count (iter_count_ff),
      .status              (status),
      .cmd                 (cmd),
      .busy                (busy),
      .rsp_valid           (rsp_valid)
   );

   mfdi_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_coupling      (req_coupling),
      .req_start_density (req_start_density),
      .cfg_degree        (degree_ff),
      .cfg_low_threshold (low_thresh_ff),
      .cfg_noise_rate    (noise_rate_ff),
      .final_density     (rsp_final_density)
   );

endmodule

// ===== rtl/mfdi_ctrl.sv =====
// Sequencer for the density iterator: item prologue, map iterations, result strobe.
`timescale 1ns / 1ps
module mfdi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [15:0]         cfg_iteration_count,
   input  mfdi_pkg::stat_type  status,
   output mfdi_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_PASCAL = 14'b00000000000010,
      ST_RATE   = 14'b00000000000100,
      ST_DIV    = 14'b00000000001000,
      ST_RD_A   = 14'b00000000010000,
      ST_RD_B   = 14'b00000000100000,
      ST_INTERP = 14'b00000001000000,
      ST_CP     = 14'b00000010000000,
      ST_TW     = 14'b00000100000000,
      ST_TT     = 14'b00001000000000,
      ST_TACC   = 14'b00010000000000,
      ST_FIN    = 14'b00100000000000,
      ST_DONE   = 14'b01000000000000,
      ST_SPARE  = 14'b10000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] iter_ff, iter_in;
   logic        no_iter;

   assign no_iter = (cfg_iteration_count == 16'd0);

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd.op   = mfdi_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = mfdi_pkg::OP_LOAD;
               iter_in  = 16'd0;
               state_in = ST_PASCAL;
            end
         end
         ST_PASCAL: begin
            cmd.op = mfdi_pkg::OP_PASCAL;
            if (status.last) state_in = ST_RATE;
         end
         ST_RATE: begin
            cmd.op = mfdi_pkg::OP_RATE;
            if (status.band) state_in = ST_DIV;
            else if (status.last) state_in = no_iter ? ST_DONE : ST_CP;
         end
         ST_DIV: begin
            cmd.op = mfdi_pkg::OP_DIV;
            if (status.div_last) state_in = ST_RD_A;
         end
         ST_RD_A: begin
            cmd.op   = mfdi_pkg::OP_RD_A;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.op   = mfdi_pkg::OP_RD_B;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.op = mfdi_pkg::OP_INTERP;
            if (status.last) state_in = no_iter ? ST_DONE : ST_CP;
            else state_in = ST_RATE;
         end
         ST_CP: begin
            cmd.op = mfdi_pkg::OP_CP;
            if (status.last) state_in = ST_TW;
         end
         ST_TW: begin
            cmd.op   = mfdi_pkg::OP_TW;
            state_in = ST_TT;
         end
         ST_TT: begin
            cmd.op   = mfdi_pkg::OP_TT;
            state_in = ST_TACC;
         end
         ST_TACC: begin
            cmd.op   = mfdi_pkg::OP_TACC;
            state_in = status.last ? ST_FIN : ST_TW;
         end
         ST_FIN: begin
            cmd.op   = mfdi_pkg::OP_FIN;
            iter_in  = iter_ff + 16'd1;
            state_in = (iter_ff + 16'd1 == cfg_iteration_count) ? ST_DONE : ST_CP;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= 16'd0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// ===== rtl/mfdi_datapath.sv =====
// Arithmetic of the density iterator: rate table, powers, Bernstein sum, divider, table ROM.
`timescale 1ns / 1ps
module mfdi_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  mfdi_pkg::cmd_type        cmd,
   output mfdi_pkg::stat_type       status,
   input  logic signed [15:0]       req_coupling,
   input  logic [16:0]              req_start_density,
   input  logic [4:0]               cfg_degree,
   input  logic [16:0]              cfg_low_threshold,
   input  logic [16:0]              cfg_noise_rate,
   output logic [16:0]              final_density
);

   localparam int DW   = mfdi_pkg::DEG_W;
   localparam int MD   = mfdi_pkg::MAX_DEGREE;
   localparam int PW   = mfdi_pkg::POW_W;
   localparam int RW   = mfdi_pkg::ROW_W;
   localparam int SW   = mfdi_pkg::SUM_W;
   localparam int VW   = mfdi_pkg::DIV_W;
   localparam int CW   = mfdi_pkg::DCNT_W;
   localparam int QW   = mfdi_pkg::QIDX_W;
   localparam int AW   = mfdi_pkg::TAB_AW;
   localparam int LIMW = 18 + DW + 1;
   localparam int BSH  = mfdi_pkg::TABLE_BITS + 1;

   localparam mfdi_pkg::lut_type LUT = mfdi_pkg::build_logistic();

   // latched item parameters
   logic [DW-1:0]      k_ff, k_in;
   logic [16:0]        q_ff, q_in;
   logic [16:0]        eps_ff, eps_in;
   logic signed [15:0] cp_ff, cp_in;
   logic [16:0]        cur_ff, cur_in;
   logic [DW-1:0]      idx_ff, idx_in;

   // per-item tables
   logic [RW-1:0]      row_ff [0:MD];
   logic [RW-1:0]      row_in [0:MD];
   logic [16:0]        tau_ff [0:MD];
   logic [16:0]        tau_in [0:MD];
   logic [PW-1:0]      comp_ff [0:MD];
   logic [PW-1:0]      comp_in [0:MD];

   // term pipeline
   logic [PW-1:0]      pd_ff, pd_in;
   logic [PW-1:0]      w_ff, w_in;
   logic [PW-1:0]      t_ff, t_in;
   logic [SW-1:0]      sum_ff, sum_in;

   // divider and table read
   logic [DW-1:0]      rem_ff, rem_in;
   logic [VW-1:0]      quo_ff, quo_in;
   logic [CW-1:0]      dcnt_ff, dcnt_in;
   logic               flip_ff, flip_in;
   logic [16:0]        t0_ff, t0_in;
   logic [16:0]        rd_data_ff;
   logic [AW-1:0]      rd_addr;

   // combinational helpers
   logic                   last;
   logic signed [17:0]     q_s;
   logic signed [17:0]     qc_s;
   logic signed [DW:0]     k_s;
   logic signed [LIMW-1:0] hi_s;
   logic signed [LIMW-1:0] lo_lim;
   logic signed [LIMW-1:0] up_lim;
   logic                   is_low;
   logic                   is_high;
   logic signed [DW+1:0]   dir_s;
   logic [DW-1:0]          ad;
   logic [15:0]            ac;
   logic [15+DW:0]         acad;
   logic                   flip_now;
   logic [DW:0]            trial;
   logic                   ge;
   logic [QW-1:0]          qidx;
   logic                   tsat;
   logic [AW-1:0]          addr_a;
   logic [AW-1:0]          addr_b;
   logic [15:0]            frac;
   logic [16:0]            diff;
   logic [33:0]            ip;
   logic [16:0]            v;
   logic [16:0]            v_out;
   logic [DW-1:0]          jc;
   logic [16:0]            cc;
   logic [PW+17:0]         cprod;
   logic [2*PW:0]          wprod;
   logic [PW+17:0]         tprod;
   logic [PW+17:0]         pprod;
   logic [SW:0]            dsum;
   logic [SW-14:0]         dval;
   logic [16:0]            sd_sat;
   logic [DW-1:0]          k_eff;

   assign last = (idx_ff == k_ff);

   // item parameter conditioning at load
   always_comb begin
      if (cfg_degree == 5'd0) k_eff = DW'(1);
      else if (32'(cfg_degree) > MD) k_eff = DW'(MD);
      else k_eff = DW'(cfg_degree);
      sd_sat = (req_start_density > mfdi_pkg::ONE_Q16) ? mfdi_pkg::ONE_Q16
                                                       : req_start_density;
   end

   // band decision for term index idx
   always_comb begin
      q_s     = $signed({1'b0, q_ff});
      qc_s    = 18'sh10000 - q_s;
      k_s     = $signed({1'b0, k_ff});
      hi_s    = $signed({{(LIMW - DW - 16){1'b0}}, idx_ff, 16'b0});
      lo_lim  = q_s * k_s;
      up_lim  = qc_s * k_s;
      is_low  = (hi_s < lo_lim);
      is_high = (hi_s > up_lim);
      dir_s   = $signed({1'b0, idx_ff, 1'b0}) - $signed({2'b0, k_ff});
      ad      = dir_s[DW+1] ? DW'(-dir_s) : DW'(dir_s);
      ac      = cp_ff[15] ? 16'(-cp_ff) : 16'(cp_ff);
      acad    = ac * ad;
      flip_now = (cp_ff[15] != dir_s[DW+1]) && (cp_ff != 16'sd0) && (dir_s != '0);
   end

   // restoring divide step and table addressing
   always_comb begin
      trial  = {rem_ff, quo_ff[VW-1]};
      ge     = (trial >= {1'b0, k_ff});
      qidx   = quo_ff[VW-1:16];
      tsat   = (32'(qidx) >= mfdi_pkg::TABLE_SIZE);
      addr_a = tsat ? AW'(mfdi_pkg::TABLE_SIZE) : AW'(qidx);
      addr_b = tsat ? AW'(mfdi_pkg::TABLE_SIZE) : AW'(qidx) + AW'(1);
      frac   = tsat ? 16'd0 : quo_ff[15:0];
      rd_addr = (cmd.op == mfdi_pkg::OP_RD_B) ? addr_b : addr_a;
   end

   // interpolation between the two samples
   always_comb begin
      diff  = rd_data_ff - t0_ff;
      ip    = 34'(diff * frac) + 34'd32768;
      v     = t0_ff + 17'(ip >> 16);
      v_out = flip_ff ? (mfdi_pkg::ONE_Q16 - v) : v;
   end

   // power and term products
   always_comb begin
      jc    = k_ff - idx_ff;
      cc    = mfdi_pkg::ONE_Q16 - cur_ff;
      cprod = (PW + 18)'(comp_ff[idx_ff - DW'(1)] * cc) + (PW + 18)'(32768);
      wprod = (2 * PW + 1)'(pd_ff * comp_ff[jc]) + (2 * PW + 1)'(32'h2000_0000);
      tprod = (PW + 18)'(w_ff * tau_ff[idx_ff]) + (PW + 18)'(32768);
      pprod = (PW + 18)'(pd_ff * cur_ff) + (PW + 18)'(32768);
      dsum  = {1'b0, sum_ff} + (SW + 1)'(8192);
      dval  = dsum[SW:14];
   end

   // next-state selection by command
   always_comb begin
      k_in    = k_ff;
      q_in    = q_ff;
      eps_in  = eps_ff;
      cp_in   = cp_ff;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      row_in  = row_ff;
      tau_in  = tau_ff;
      comp_in = comp_ff;
      pd_in   = pd_ff;
      w_in    = w_ff;
      t_in    = t_ff;
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      flip_in = flip_ff;
      t0_in   = t0_ff;
      unique case (cmd.op)
         mfdi_pkg::OP_LOAD: begin
            k_in   = k_eff;
            q_in   = cfg_low_threshold;
            eps_in = (cfg_noise_rate > mfdi_pkg::ONE_Q16) ? mfdi_pkg::ONE_Q16
                                                          : cfg_noise_rate;
            cp_in  = req_coupling;
            cur_in = sd_sat;
            idx_in = DW'(1);
            for (int j = 0; j <= MD; j++) row_in[j] = '0;
            row_in[0]  = RW'(1);
            comp_in[0] = mfdi_pkg::ONE_POW;
         end
         mfdi_pkg::OP_PASCAL: begin
            for (int j = 1; j <= MD; j++) row_in[j] = row_ff[j] + row_ff[j-1];
            idx_in = last ? '0 : idx_ff + DW'(1);
         end
         mfdi_pkg::OP_RATE: begin
            if (is_low || is_high) begin
               tau_in[idx_ff] = is_low ? eps_ff : (mfdi_pkg::ONE_Q16 - eps_ff);
               idx_in = last ? DW'(1) : idx_ff + DW'(1);
            end else begin
               quo_in  = {acad, {BSH{1'b0}}};
               rem_in  = '0;
               dcnt_in = '0;
               flip_in = flip_now;
            end
         end
         mfdi_pkg::OP_DIV: begin
            rem_in  = ge ? DW'(trial - {1'b0, k_ff}) : trial[DW-1:0];
            quo_in  = {quo_ff[VW-2:0], ge};
            dcnt_in = dcnt_ff + CW'(1);
         end
         mfdi_pkg::OP_RD_A: begin
         end
         mfdi_pkg::OP_RD_B: begin
            t0_in = rd_data_ff;
         end
         mfdi_pkg::OP_INTERP: begin
            tau_in[idx_ff] = v_out;
            idx_in = last ? DW'(1) : idx_ff + DW'(1);
         end
         mfdi_pkg::OP_CP: begin
            comp_in[idx_ff] = cprod[PW+15:16];
            if (last) begin
               idx_in = '0;
               sum_in = '0;
               pd_in  = mfdi_pkg::ONE_POW;
            end else begin
               idx_in = idx_ff + DW'(1);
            end
         end
         mfdi_pkg::OP_TW: begin
            w_in = wprod[PW+29:30];
         end
         mfdi_pkg::OP_TT: begin
            t_in = tprod[PW+15:16];
         end
         mfdi_pkg::OP_TACC: begin
            sum_in = sum_ff + SW'(row_ff[idx_ff] * t_ff);
            pd_in  = pprod[PW+15:16];
            idx_in = last ? '0 : idx_ff + DW'(1);
         end
         mfdi_pkg::OP_FIN: begin
            cur_in = (dval > (SW - 13)'(mfdi_pkg::ONE_Q16)) ? mfdi_pkg::ONE_Q16
                                                             : dval[16:0];
            idx_in = DW'(1);
         end
         default: begin
         end
      endcase
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         dcnt_ff <= dcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      q_ff    <= q_in;
      eps_ff  <= eps_in;
      cp_ff   <= cp_in;
      cur_ff  <= cur_in;
      row_ff  <= row_in;
      tau_ff  <= tau_in;
      comp_ff <= comp_in;
      pd_ff   <= pd_in;
      w_ff    <= w_in;
      t_ff    <= t_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      flip_ff <= flip_in;
      t0_ff   <= t0_in;
   end

   // logistic ROM, registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= LUT[rd_addr];
   end

   assign status.last     = last;
   assign status.band     = !(is_low || is_high);
   assign status.div_last = (dcnt_ff == CW'(VW - 1));
   assign final_density   = cur_ff;

endmodule

// ===== rtl/mfdi_checker.sv =====
// Port-level checks for the density iterator, bound to the top level.
`timescale 1ns / 1ps
module mfdi_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [16:0]        rsp_final_density
);

   // an accepted transfer makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // the result strobe is a single-cycle pulse
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the result only appears while an item is in work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // result is saturated to one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_density <= 17'h10000))
      else $error("result density above one");

   // reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind mean_field_density_iterator mfdi_checker u_mfdi_checker (.*);

// ===== sim/mean_field_density_iterator_test.sv =====
// Self-checking testbench for the mean-field density iterator.
`timescale 1ns / 1ps
module mean_field_density_iterator_test;

   localparam longint CYCLE_LIMIT = 5_000_000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_coupling;
   logic [16:0]        req_start_density;
   logic               rsp_valid;
   logic [16:0]        rsp_final_density;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [16:0]        csr_data;

   mean_field_density_iterator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coupling(req_coupling), .req_start_density(req_start_density),
      .rsp_valid(rsp_valid), .rsp_final_density(rsp_final_density),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor copy of the register bank
   int unsigned   cfg_degree;
   int unsigned   cfg_low_threshold;
   int unsigned   cfg_noise_rate;
   int unsigned   cfg_iterations;
   bit [16:0]     logistic_rom [0:mfdi_pkg::TABLE_SIZE];
   logic [16:0]   density_queue [$];
   int            error_count;
   longint        cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // logistic samples: exp(-16/TABLE_SIZE) by Taylor series in Q2.62, then products
   function automatic void fill_logistic_rom();
      bit [63:0] term, ratio, ex, den, a1, a0, b1, b0, mid;
      term  = 64'h4000_0000_0000_0000;
      ratio = term;
      ex    = term;
      for (int m = 1; m < 64; m++) begin
         if (term != 0) begin
            term = (term >> (mfdi_pkg::TABLE_BITS - 4)) / 64'(m);
            if (m % 2 == 1) ratio = ratio - term;
            else ratio = ratio + term;
         end
      end
      for (int n = 0; n <= mfdi_pkg::TABLE_SIZE; n++) begin
         den = 64'h4000_0000 + (ex >> 32);
         logistic_rom[n] = 17'(((64'd1 << 46) + den / 2) / den);
         a1  = ex >> 31;
         a0  = ex & 64'h7FFF_FFFF;
         b1  = ratio >> 31;
         b0  = ratio & 64'h7FFF_FFFF;
         mid = a1 * b0 + a0 * b1 + ((a0 * b0) >> 31);
         ex  = a1 * b1 + (mid >> 31);
      end
   endfunction

   function automatic bit [63:0] logistic_lookup(int cp, int dir, int unsigned k);
      bit [63:0] ac, ad, pos, idx, frac, v, t0, t1;
      ac  = (cp < 0) ? -cp : cp;
      ad  = (dir < 0) ? -dir : dir;
      pos = ((ac * ad) << (mfdi_pkg::TABLE_BITS + 1)) / k;
      idx = pos >> 16;
      if (idx >= mfdi_pkg::TABLE_SIZE) begin
         v = logistic_rom[mfdi_pkg::TABLE_SIZE];
      end else begin
         t0   = logistic_rom[idx];
         t1   = logistic_rom[idx + 1];
         frac = pos & 64'hFFFF;
         v    = 32'(t0 + ((32'(t1 - t0) * frac + 32768) >> 16));
      end
      if (((cp < 0) != (dir < 0)) && cp != 0 && dir != 0) v = 65536 - v;
      return v;
   endfunction

   function automatic bit [63:0] tau_rate(int unsigned i, int unsigned k, int cp,
                                          bit [63:0] eps);
      longint hi, q;
      hi = longint'(i) * 65536;
      q  = cfg_low_threshold;
      if (hi < q * k) return eps;
      if (hi <= (65536 - q) * k) return logistic_lookup(cp, 2 * int'(i) - int'(k), k);
      return 65536 - eps;
   endfunction

   // one application of the Bernstein-weighted map
   function automatic bit [63:0] density_step(bit [63:0] c, int unsigned k, int cp,
                                              bit [63:0] eps);
      bit [63:0] comp_pow [0:mfdi_pkg::MAX_DEGREE];
      bit [63:0] sum, binom, pd, w, t, d;
      comp_pow[0] = 64'd1 << 30;
      for (int j = 1; j <= k; j++) comp_pow[j] = (comp_pow[j-1] * (65536 - c) + 32768) >> 16;
      sum   = 0;
      binom = 1;
      pd    = 64'd1 << 30;
      for (int unsigned i = 0; i <= k; i++) begin
         w     = (pd * comp_pow[k - i] + (64'd1 << 29)) >> 30;
         t     = (w * tau_rate(i, k, cp, eps) + 32768) >> 16;
         sum   = sum + binom * t;
         binom = binom * (k - i) / (i + 1);
         pd    = (pd * c + 32768) >> 16;
      end
      d = 32'((sum + (64'd1 << 13)) >> 14);
      return (d > 65536) ? 64'd65536 : d;
   endfunction

   function automatic logic [16:0] predict_density(logic signed [15:0] coupling,
                                                   logic [16:0] start_density);
      int unsigned k;
      bit [63:0]   eps, c;
      k   = (cfg_degree == 0) ? 1 : cfg_degree;
      if (k > mfdi_pkg::MAX_DEGREE) k = mfdi_pkg::MAX_DEGREE;
      eps = (cfg_noise_rate > 65536) ? 64'd65536 : 64'(cfg_noise_rate);
      c   = (start_density > mfdi_pkg::ONE_Q16) ? 64'd65536 : 64'(start_density);
      for (int unsigned n = 0; n < cfg_iterations; n++)
         c = density_step(c, k, int'(coupling), eps);
      return 17'(c);
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (density_queue.size() == 0) begin
            $error("final_density: no result expected, actual %0d", rsp_final_density);
            error_count++;
         end else begin
            if (rsp_final_density !== density_queue[0]) begin
               $error("final_density: expected %0d, actual %0d",
                      density_queue[0], rsp_final_density);
               error_count++;
            end
            void'(density_queue.pop_front());
         end
      end
   end

   // one item transfer after a random gap; start stays high for back-to-back items
   task automatic send_item(logic signed [15:0] coupling, logic [16:0] start_density);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_coupling      <= coupling;
      req_start_density <= start_density;
      do @(posedge clock); while (busy);
      density_queue.push_back(predict_density(coupling, start_density));
   endtask

   // drop start and wait until every expected result has arrived
   task automatic drain();
      @(posedge clock);
      start <= 1'b0;
      while (density_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write; the caller drops csr_valid after the last one
   task automatic write_reg(logic [1:0] index, logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         mfdi_pkg::REG_DEGREE:     cfg_degree = value & 17'h1F;
         mfdi_pkg::REG_LOW_THRESH: cfg_low_threshold = value;
         mfdi_pkg::REG_NOISE_RATE: cfg_noise_rate = value;
         mfdi_pkg::REG_ITER_COUNT: cfg_iterations = value & 17'hFFFF;
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned k, int unsigned q, int unsigned eps,
                            int unsigned n);
      drain();
      write_reg(mfdi_pkg::REG_DEGREE, 17'(k));
      write_reg(mfdi_pkg::REG_LOW_THRESH, 17'(q));
      write_reg(mfdi_pkg::REG_NOISE_RATE, 17'(eps));
      write_reg(mfdi_pkg::REG_ITER_COUNT, 17'(n));
      csr_valid <= 1'b0;
   endtask

   // reset values: degree 4, 1000 iterations
   task automatic test_reset_config();
      send_item(16'sd0, 17'd0);
      send_item(16'sd32767, 17'd65536);
   endtask

   // degree zero, one, the maximum and beyond; field extremes
   task automatic test_degree_extremes();
      configure(0, 0, 0, 3);
      send_item(-16'sd32768, 17'd131071);
      configure(1, 0, 0, 3);
      send_item(16'sd32767, 17'd0);
      send_item(16'sd4096, 17'd32768);
      configure(16, 0, 0, 3);
      send_item(-16'sd32768, 17'd65536);
      send_item(16'sd12000, 17'd30000);
      configure(31, 0, 0, 2);
      send_item(-16'sd5000, 17'd40000);
   endtask

   // thresholds and noise rates at and above one, then at mid-range values
   task automatic test_noise_band();
      configure(8, 65536, 65536, 2);
      send_item(16'sd3000, 17'd20000);
      configure(8, 131071, 131071, 2);
      send_item(-16'sd3000, 17'd50000);
      configure(6, 16384, 3000, 4);
      send_item(16'sd8192, 17'd10000);
      send_item(-16'sd8192, 17'd60000);
   endtask

   // zero iterations pass the saturated start density through
   task automatic test_zero_iterations();
      configure(4, 0, 0, 0);
      send_item(16'sd100, 17'd100000);
      send_item(-16'sd100, 17'd1234);
   endtask

   // longest iteration count at the smallest degree
   task automatic test_max_iterations();
      configure(1, 1000, 500, 65535);
      send_item(16'sd2000, 17'd45000);
   endtask

   task automatic test_random();
      logic [16:0] sd;
      for (int phase = 0; phase < 6; phase++) begin
         configure(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(0, 20000),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(0, 8000),
                   $urandom_range(0, 6));
         repeat (17) begin
            sd = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                             : 17'($urandom_range(0, 65536));
            send_item(16'($urandom), sd);
         end
      end
   endtask

   initial begin
      error_count       = 0;
      density_queue     = {};
      cfg_degree        = 4;
      cfg_low_threshold = 0;
      cfg_noise_rate    = 0;
      cfg_iterations    = 1000;
      fill_logistic_rom();
      reset             = 1'b1;
      start             = 1'b0;
      req_coupling      = '0;
      req_start_density = '0;
      csr_valid         = 1'b0;
      csr_index         = mfdi_pkg::REG_DEGREE;
      csr_data          = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_degree_extremes();
      test_noise_band();
      test_zero_iterations();
      test_max_iterations();
      test_random();
      drain();
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mfdi_pkg.sv
rtl/mfdi_ctrl.sv
rtl/mfdi_datapath.sv
rtl/mean_field_density_iterator.sv
rtl/mfdi_checker.sv
sim/mean_field_density_iterator_test.sv
